// ===== design/rmf_pkg.sv =====
// Shared types and constants of the RGB 3x3 mean filter.
package rmf_pkg;

	localparam int CFG_DATA_W  = 32;
	localparam int SIZE_W      = 11;
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 3 * CHAN_W;
	localparam int SUM_W       = 12;  // nine 8-bit values
	localparam int CNT_W       = 4;   // up to nine neighbours

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1000);

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [CHAN_W-1:0] pix_red;
		logic [CHAN_W-1:0] pix_green;
		logic [CHAN_W-1:0] pix_blue;
	} pixel_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] mean_red;
		logic [CHAN_W-1:0] mean_green;
		logic [CHAN_W-1:0] mean_blue;
		logic              frame_end;
	} mean_out_t;

endpackage

// ===== design/rmf_mean_div.sv =====
// Divides a neighbourhood sum by its neighbour count with a reciprocal multiply.
module rmf_mean_div
	import rmf_pkg::*;
(
	input  logic [SUM_W-1:0]  sum,
	input  logic [CNT_W-1:0]  count,
	output logic [CHAN_W-1:0] mean
);

	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	// ceil(2^18 / d); exact for every sum below 2^15
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
		logic [RECIP_W-1:0] r;
		unique case (d)
			CNT_W'(2): r = RECIP_W'(131072);
			CNT_W'(3): r = RECIP_W'(87382);
			CNT_W'(4): r = RECIP_W'(65536);
			CNT_W'(5): r = RECIP_W'(52429);
			CNT_W'(6): r = RECIP_W'(43691);
			CNT_W'(7): r = RECIP_W'(37450);
			CNT_W'(8): r = RECIP_W'(32768);
			CNT_W'(9): r = RECIP_W'(29128);
			default:   r = RECIP_W'(262144);  // one, and counts that cannot occur
		endcase
		return r;
	endfunction

	logic [SUM_W+RECIP_W-1:0] product;

	assign product = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(recip(count));
	assign mean    = product[RECIP_SHIFT +: CHAN_W];

endmodule

// ===== design/rgb_mean_filter_3x3.sv =====
// Streaming 3x3 mean filter for RGB888 pixels in raster order: one item per clock unless the output stalls.
// Each pixel item costs one read of the line memory (two rows packed in one 48-bit word)
// and one write back from stage 1; a write to the column just being read is forwarded, so
// even one-pixel-wide images run at full rate. A result is registered at the output after the item
// that completes its neighbourhood, which is one row plus one pixel after its centre pixel.
// After the last pixel of a frame, image_width+1 drain items flush the remaining results;
// the last one carries frame_end and the next item starts a new frame. Edge and corner
// pixels average only the neighbours inside the image, truncating. Register writes (width
// at byte 0, height at byte 4) restart the frame; sizes of zero act as one and sizes above
// MAX_WIDTH or MAX_HEIGHT act as that maximum. The line memory needs no clearing after reset.
module rgb_mean_filter_3x3
	import rmf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel items in
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pixel_in_t             in_item,
	// mean items out
	output logic                  out_valid,
	input  logic                  out_stall,
	output mean_out_t             out_item,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int COL_W  = $clog2(MAX_WIDTH);       // column address
	localparam int WDIM_W = $clog2(MAX_WIDTH + 2);   // holds width + 1
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);  // in_row runs past height while draining

	// ---------------------------------------------------------------- registers
	logic [SIZE_W-1:0] image_width_q, image_height_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= SIZE_RESET;
			image_height_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[SIZE_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (paddr[1:0] != 2'b00) begin
			prdata = '0;
		end else begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width_q);
				REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height_q);
			endcase
		end
	end

	// sizes in use, clamped to 1..MAX
	logic [WDIM_W-1:0] w_dim, w_plus1;
	logic [ROW_W-1:0]  h_dim;

	always_comb begin
		if (image_width_q == '0)
			w_dim = WDIM_W'(1);
		else if (32'(image_width_q) > MAX_WIDTH)
			w_dim = WDIM_W'(MAX_WIDTH);
		else
			w_dim = WDIM_W'(image_width_q);
		if (image_height_q == '0)
			h_dim = ROW_W'(1);
		else if (32'(image_height_q) > MAX_HEIGHT)
			h_dim = ROW_W'(MAX_HEIGHT);
		else
			h_dim = ROW_W'(image_height_q);
	end

	assign w_plus1 = w_dim + 1'b1;

	// raster positions of the next item and the next result centre
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [WDIM_W-1:0] pending_q;

	// ---------------------------------------------------------------- pipeline control
	// Whole pipeline moves together; it only halts while a result waits at a stalled output.
	logic advance, accept, in_frame, take;

	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;
	assign accept   = in_valid && advance;
	assign in_frame = in_row_q < h_dim;
	// a drain item before the frame is complete is dropped without effect
	assign take     = accept && !(in_frame && (in_item.operation == OP_DRAIN));

	// ---------------------------------------------------------------- position tracking
	logic              emit, last, col_wrap, out_col_wrap;
	logic [8:0]        mask;

	assign emit         = pending_q >= w_plus1;
	assign last         = (out_row_q == h_dim - 1'b1) && (WDIM_W'(out_col_q) == w_dim - 1'b1);
	assign col_wrap     = (WDIM_W'(in_col_q) + 1'b1) >= w_dim;
	assign out_col_wrap = (WDIM_W'(out_col_q) + 1'b1) >= w_dim;

	// which of the nine window places lie inside the image, top-left first
	always_comb begin
		logic [2:0] row_ok, col_ok;
		row_ok = {(out_row_q + 1'b1) < h_dim, 1'b1, out_row_q != '0};
		col_ok = {(WDIM_W'(out_col_q) + 1'b1) < w_dim, 1'b1, out_col_q != '0};
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				mask[r*3 + c] = row_ok[r] & col_ok[c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (cfg_wr) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (take) begin
			if (emit && last) begin
				// frame done: next item is pixel (0,0)
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				pending_q <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (emit) begin
					pending_q <= w_plus1;
					if (out_col_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end else begin
					pending_q <= pending_q + 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- line memory
	// word = {two rows above, one row above} for each column
	logic [2*PIX_W-1:0] row_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q, fwd_q, row_data, wr_data;
	logic               fwd_hit_q, wr_en;

	logic               s1_valid, s1_in_frame, s1_emit, s1_last;
	logic [COL_W-1:0]   s1_col;
	logic [PIX_W-1:0]   s1_pix;
	logic [8:0]         s1_mask;

	assign row_data = fwd_hit_q ? fwd_q : rd_q;
	assign wr_en    = advance && s1_valid && s1_in_frame;
	assign wr_data  = {row_data[PIX_W-1:0], s1_pix};

	always_ff @(posedge clk) begin
		if (take)
			rd_q <= row_mem[in_col_q];
		if (wr_en)
			row_mem[s1_col] <= wr_data;
		if (take)
			fwd_q <= wr_data;
	end

	// same column read while it is written back: only for one-pixel-wide images
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_hit_q <= 1'b0;
		else if (take)
			fwd_hit_q <= wr_en && (s1_col == in_col_q);
	end

	// ---------------------------------------------------------------- stage 1: memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (advance)
			s1_valid <= take && !cfg_wr;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_in_frame <= in_frame;
			s1_col      <= in_col_q;
			s1_pix      <= {in_item.pix_red, in_item.pix_green, in_item.pix_blue};
			s1_emit     <= emit;
			s1_last     <= last;
			s1_mask     <= mask;
		end
	end

	// ---------------------------------------------------------------- window
	// rows: two above, one above, incoming; columns: oldest to newest
	logic [PIX_W-1:0] win_q [9];
	logic [PIX_W-1:0] col_new [3];

	assign col_new[0] = row_data[2*PIX_W-1:PIX_W];
	assign col_new[1] = row_data[PIX_W-1:0];
	assign col_new[2] = s1_in_frame ? s1_pix : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (advance && s1_valid) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3 + 0] <= win_q[k*3 + 1];
				win_q[k*3 + 1] <= win_q[k*3 + 2];
				win_q[k*3 + 2] <= col_new[k];
			end
		end
	end

	// ---------------------------------------------------------------- stage 2: window sums
	logic       s2_valid, s2_last;
	logic [8:0] s2_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_valid <= 1'b0;
		else if (advance)
			s2_valid <= s1_valid && s1_emit;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s2_last <= s1_last;
			s2_mask <= s1_mask;
		end
	end

	logic [SUM_W-1:0] sum_c [3];
	logic [CNT_W-1:0] count_c;

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			sum_c[ch] = '0;
		for (int i = 0; i < 9; i++) begin
			if (s2_mask[i]) begin
				for (int ch = 0; ch < 3; ch++)
					sum_c[ch] = sum_c[ch] + SUM_W'(win_q[i][(2-ch)*CHAN_W +: CHAN_W]);
			end
		end
		count_c = CNT_W'($countones(s2_mask));
	end

	// ---------------------------------------------------------------- stage 3: divide
	logic             s3_valid, s3_last;
	logic [SUM_W-1:0] s3_sum [3];
	logic [CNT_W-1:0] s3_count;
	logic [CHAN_W-1:0] mean_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s3_valid <= 1'b0;
		else if (advance)
			s3_valid <= s2_valid;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s3_last  <= s2_last;
			s3_count <= count_c;
			for (int ch = 0; ch < 3; ch++)
				s3_sum[ch] <= sum_c[ch];
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_div
		rmf_mean_div u_div (
			.sum   (s3_sum[ch]),
			.count (s3_count),
			.mean  (mean_c[ch])
		);
	end

	// ---------------------------------------------------------------- output register
	logic      out_valid_q;
	mean_out_t out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= s3_valid;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.mean_red   <= mean_c[0];
			out_item_q.mean_green <= mean_c[1];
			out_item_q.mean_blue  <= mean_c[2];
			out_item_q.frame_end  <= s3_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== verif/rmf_checker.sv =====
// Checker for the RGB 3x3 mean filter: predicts each mean item and compares it with the block.
`timescale 1ns / 100ps
module rmf_checker
	import rmf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  pixel_in_t             in_item,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  mean_out_t             out_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic [CFG_DATA_W-1:0] prdata,
	input  logic                  pready,
	output int                    fail_count,
	output int                    outstanding,
	output int                    means_checked,
	output int                    frames_closed
);

	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;
	logic [PIX_W-1:0]  upper_row [MAX_WIDTH];
	logic [PIX_W-1:0]  lower_row [MAX_WIDTH];
	logic [PIX_W-1:0]  win [9];
	int                col_in, row_in, col_out, row_out, backlog;
	int                fails, checked, frames;
	mean_out_t         mean_q [$];

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic int size_in_use(input logic [SIZE_W-1:0] v, input int maxv);
		if (v == '0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	task automatic restart_frame();
		col_in  = 0;
		row_in  = 0;
		col_out = 0;
		row_out = 0;
		backlog = 0;
	endtask

	task automatic check_field(input string name, input logic [CHAN_W-1:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// one accepted pixel item: shift the window, then emit the mean it completes, if any
	task automatic take_item(input pixel_in_t it);
		int               w, h, col, cnt, rr, cc;
		int               sum_r, sum_g, sum_b;
		logic [PIX_W-1:0] fresh [3];
		logic [PIX_W-1:0] px;
		logic             live, last;
		mean_out_t        want;
		w    = size_in_use(width_reg, MAX_WIDTH);
		h    = size_in_use(height_reg, MAX_HEIGHT);
		live = (row_in < h);
		if (live && it.operation == OP_DRAIN)
			return;
		col = (col_in >= MAX_WIDTH) ? 0 : col_in;
		fresh[0] = upper_row[col];
		fresh[1] = lower_row[col];
		fresh[2] = live ? {it.pix_red, it.pix_green, it.pix_blue} : '0;
		if (live) begin
			upper_row[col] = fresh[1];
			lower_row[col] = fresh[2];
		end
		for (int k = 0; k < 3; k++) begin
			win[k*3 + 0] = win[k*3 + 1];
			win[k*3 + 1] = win[k*3 + 2];
			win[k*3 + 2] = fresh[k];
		end
		col_in++;
		if (col_in >= w) begin
			col_in = 0;
			row_in++;
		end
		backlog++;
		if (backlog < w + 2)
			return;
		backlog = w + 1;

		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		cnt   = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				rr = row_out + dr;
				cc = col_out + dc;
				if (rr >= 0 && cc >= 0 && rr < h && cc < w) begin
					px = win[(dr + 1)*3 + (dc + 1)];
					sum_r += px[3*CHAN_W-1:2*CHAN_W];
					sum_g += px[2*CHAN_W-1:CHAN_W];
					sum_b += px[CHAN_W-1:0];
					cnt++;
				end
			end
		end
		if (cnt == 0)
			cnt = 1;
		last = (row_out == h - 1) && (col_out == w - 1);
		want.mean_red   = CHAN_W'(sum_r / cnt);
		want.mean_green = CHAN_W'(sum_g / cnt);
		want.mean_blue  = CHAN_W'(sum_b / cnt);
		want.frame_end  = last;
		mean_q.push_back(want);
		if (last) begin
			restart_frame();
		end else begin
			col_out++;
			if (col_out >= w) begin
				col_out = 0;
				row_out++;
			end
		end
	endtask

	task automatic match_result();
		mean_out_t want;
		if (mean_q.size() == 0) begin
			$error("mean item with none pending: red %0d green %0d blue %0d frame_end %0b",
				out_item.mean_red, out_item.mean_green, out_item.mean_blue,
				out_item.frame_end);
			fails++;
			return;
		end
		want = mean_q.pop_front();
		checked++;
		if (want.frame_end)
			frames++;
		check_field("mean_red", want.mean_red, out_item.mean_red);
		check_field("mean_green", want.mean_green, out_item.mean_green);
		check_field("mean_blue", want.mean_blue, out_item.mean_blue);
		check_field("frame_end", CHAN_W'(want.frame_end), CHAN_W'(out_item.frame_end));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [SIZE_W-1:0] readback;
		if (!arst_n) begin
			width_reg  = SIZE_RESET;
			height_reg = SIZE_RESET;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_row[i] = '0;
				lower_row[i] = '0;
			end
			for (int i = 0; i < 9; i++)
				win[i] = '0;
			restart_frame();
			mean_q.delete();
			fails   = 0;
			checked = 0;
			frames  = 0;
		end else begin
			// older items leave first, so results are matched before the new item is taken
			if (out_valid && !out_stall)
				match_result();
			if (in_valid && !in_stall)
				take_item(in_item);
			if (psel && penable && pready && paddr[1:0] == 2'b00) begin
				if (pwrite) begin
					case (paddr[2])
						REG_IMAGE_WIDTH:  width_reg  = pwdata[SIZE_W-1:0];
						REG_IMAGE_HEIGHT: height_reg = pwdata[SIZE_W-1:0];
					endcase
					restart_frame();
				end else begin
					readback = (paddr[2] == REG_IMAGE_WIDTH) ? width_reg : height_reg;
					if (prdata !== CFG_DATA_W'(readback)) begin
						$error("prdata: expected %0d, got %0d", readback, prdata);
						fails++;
					end
				end
			end
		end
		fail_count    <= fails;
		outstanding   <= mean_q.size();
		means_checked <= checked;
		frames_closed <= frames;
	end

endmodule

// ===== verif/tb_rgb_mean_filter_3x3.sv =====
// Testbench top for the RGB 3x3 mean filter: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 100ps
module tb_rgb_mean_filter_3x3;
	import rmf_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int MAX_H         = 1024;
	localparam int RANDOM_ITEMS  = 620;
	localparam int QUIET_ITEMS   = 150;   // final stretch with no idling on either side
	localparam int SETTLE_CYCLES = 8;     // spare idle time after the last mean has come out
	// Slowest correct run: about 1800 items, each waiting out the longest sender gap and the
	// longest receiver stall, plus the register traffic. The limit allows several times that.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	// 3x3 frame for the directed part, raster order: three saturated corners, zero top and
	// bottom edges and a few odd values so the divisions by 4, 6 and 9 truncate
	localparam logic [9*PIX_W-1:0] TINY_FRAME = {
		24'hFFFFFF, 24'h000000, 24'hFFFFFF,
		24'h010203, 24'h808080, 24'hFE7F01,
		24'hFFFFFF, 24'h000000, 24'h00FF00
	};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	pixel_in_t             in_item;
	logic                  out_valid;
	logic                  out_stall;
	mean_out_t             out_item;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [2:0]            paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int          fail_count;
	int          outstanding;
	int          means_checked;
	int          frames_closed;
	int          items_sent  = 0;
	int          frame_items = 0;
	int          writes      = 0;
	bit          quiet       = 1'b0;  // no idling on either side once set
	bit          gaps_on     = 1'b1;  // sender gaps allowed in the current frame
	int unsigned cycle_count = 0;

	rgb_mean_filter_3x3 #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	rmf_checker #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.means_checked(means_checked),
		.frames_closed(frames_closed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver pacing: random stall bursts, some long clear stretches, none at the end
	initial begin : sink_pacing
		int n;
		out_stall = 1'b0;
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 9) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end else begin
				n = $urandom_range(1, 15);
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat (n) @(posedge clk);
			end
		end
	end

	// saturated channel values turn up often, to hit the carry and truncation corners
	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_in_t make_item(input logic op, input logic [PIX_W-1:0] rgb);
		pixel_in_t it;
		it.operation = op;
		{it.pix_red, it.pix_green, it.pix_blue} = rgb;
		return it;
	endfunction

	// hold the item until accepted, then maybe leave a gap
	task automatic send_item(input pixel_in_t it);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// sender pauses until every pending mean item has come out
	task automatic wait_means_out();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// idle point for register writes: items that give no result may still be in flight
	task automatic settle();
		wait_means_out();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup cycle then access cycle; the upper data bits are sometimes junk
	task automatic write_size(input logic idx, input logic [SIZE_W-1:0] v);
		logic [CFG_DATA_W-1:0] data;
		data = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
		data[SIZE_W-1:0] = v;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		writes++;
	endtask

	task automatic read_size(input logic idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// One frame of w x h pixels (sizes in use) and its w+1 flushing items. Tail items are
	// mostly drains, sometimes data that the block treats as a drain. Stray drains inside
	// the frame are ignored by the block. A trimmed frame stops at a random point and is
	// abandoned by the next register write.
	task automatic play_frame(input int w, input int h, input bit trim);
		int        total, stop_at, hold_at;
		logic      op;
		pixel_in_t it;
		total   = w * h;
		stop_at = trim ? int'($urandom_range(0, total + w)) : total + w + 1;
		hold_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, total + w)) : -1;
		gaps_on = ($urandom_range(0, 3) != 0);
		for (int k = 0; k < stop_at; k++) begin
			if (k == hold_at)
				wait_means_out();
			if (k < total && $urandom_range(0, 19) == 0)
				send_item(make_item(OP_DRAIN, {rand_chan(), rand_chan(), rand_chan()}));
			op = (k < total || $urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN;
			it = make_item(op, {rand_chan(), rand_chan(), rand_chan()});
			send_item(it);
			frame_items++;
		end
	endtask

	initial begin : stimulus
		logic [SIZE_W-1:0] raw_w, raw_h;
		int                w_use, h_use, start, which;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// reset sizes read back as 1000 x 1000
		read_size(REG_IMAGE_WIDTH);
		read_size(REG_IMAGE_HEIGHT);
		// a partial frame at the reset size: no neighbourhood completes, and the
		// drain in the middle of the frame is ignored
		send_item(make_item(OP_PIXEL, 24'hFFFFFF));
		send_item(make_item(OP_PIXEL, 24'h000000));
		send_item(make_item(OP_DRAIN, 24'h5A5A5A));
		send_item(make_item(OP_PIXEL, 24'hFF00FF));
		settle();

		// 3x3 image: corners average 4, edges 6, the centre 9
		write_size(REG_IMAGE_WIDTH, SIZE_W'(3));
		write_size(REG_IMAGE_HEIGHT, SIZE_W'(3));
		for (int i = 8; i >= 0; i--)
			send_item(make_item(OP_PIXEL, TINY_FRAME[i*PIX_W +: PIX_W]));
		send_item(make_item(OP_DRAIN, 24'h000000));
		send_item(make_item(OP_PIXEL, 24'h123456));  // data after the frame acts as a drain
		send_item(make_item(OP_DRAIN, 24'hFFFFFF));
		send_item(make_item(OP_DRAIN, 24'h000000));
		settle();

		// sizes of zero act as one: a single pixel is its own mean
		write_size(REG_IMAGE_WIDTH, '0);
		write_size(REG_IMAGE_HEIGHT, '0);
		read_size(REG_IMAGE_WIDTH);
		read_size(REG_IMAGE_HEIGHT);
		send_item(make_item(OP_PIXEL, 24'hFF8001));
		send_item(make_item(OP_DRAIN, 24'h000000));
		send_item(make_item(OP_PIXEL, 24'h7F7F7F));
		settle();

		// --- largest sizes ---
		// width one above the maximum acts as 1024 columns, all-ones height as 1024 rows;
		// one full row and a few pixels of the next give the first means of the top row,
		// then the next register write abandons the frame
		write_size(REG_IMAGE_WIDTH, SIZE_W'(MAX_W + 1));
		write_size(REG_IMAGE_HEIGHT, '1);
		read_size(REG_IMAGE_HEIGHT);
		for (int k = 0; k < MAX_W + 6; k++) begin
			send_item(make_item(OP_PIXEL, {rand_chan(), rand_chan(), rand_chan()}));
			frame_items++;
		end
		settle();

		// --- random part: small images, one to three frames per setting ---
		raw_w = '1;
		raw_h = '1;
		start = frame_items;
		while (!quiet || frame_items - start < RANDOM_ITEMS) begin
			which = $urandom_range(0, 3);
			// each size is rewritten whenever the previous one was above the maximum
			if (which != 1 || raw_w > SIZE_W'(MAX_W)) begin
				case ($urandom_range(0, 15))
					0: raw_w = '0;
					1, 2: raw_w = SIZE_W'($urandom_range(13, 48));
					default: raw_w = SIZE_W'($urandom_range(1, 12));
				endcase
				write_size(REG_IMAGE_WIDTH, raw_w);
			end
			if (which != 0 || raw_h > SIZE_W'(MAX_H)) begin
				case ($urandom_range(0, 11))
					0: raw_h = '0;
					1: raw_h = SIZE_W'($urandom_range(9, 16));
					default: raw_h = SIZE_W'($urandom_range(1, 8));
				endcase
				write_size(REG_IMAGE_HEIGHT, raw_h);
			end
			if ($urandom_range(0, 3) == 0) begin
				read_size(REG_IMAGE_WIDTH);
				read_size(REG_IMAGE_HEIGHT);
			end
			w_use = (raw_w == '0) ? 1 : int'(raw_w);
			h_use = (raw_h == '0) ? 1 : int'(raw_h);
			for (int f = $urandom_range(1, 3); f > 0; f--)
				play_frame(w_use, h_use, f == 1 && $urandom_range(0, 7) == 0);
			quiet = (frame_items - start > RANDOM_ITEMS - QUIET_ITEMS);
			settle();
		end

		// everything sent: let the last results out, then a few spare cycles
		wait_means_out();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		$display("run: %0d items sent, %0d of them in framed traffic, %0d register writes",
			items_sent, frame_items, writes);
		$display("run: %0d means compared across %0d complete frames, %0d mismatches",
			means_checked, frames_closed, fail_count);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/rmf_pkg.sv
design/rmf_mean_div.sv
design/rgb_mean_filter_3x3.sv
verif/rmf_checker.sv
verif/tb_rgb_mean_filter_3x3.sv
